// ===== rtl/core/pmrd_pkg.sv =====
// shared types, register codes and constants for the motor rate PID drive
package pmrd_pkg;

	// field widths
	localparam int GAIN_W     = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 3;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_PROP   = 3'd0,
		CFG_GAIN_INTEG  = 3'd1,
		CFG_GAIN_DERIV  = 3'd2,
		CFG_RATE_MODE   = 3'd3,
		CFG_MOTOR_EN    = 3'd4,
		CFG_SINGLE_PIN  = 3'd5
	} cfg_idx_t;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_PROP_RST  = 12'd77;
	localparam logic [GAIN_W-1:0] GAIN_INTEG_RST = 12'd26;
	localparam logic [GAIN_W-1:0] GAIN_DERIV_RST = 12'd26;
	localparam logic RATE_MODE_RST  = 1'b1;
	localparam logic MOTOR_EN_RST   = 1'b0;
	localparam logic SINGLE_PIN_RST = 1'b0;

	// input beat kinds
	localparam logic KIND_TARGET = 1'b0;
	localparam logic KIND_TICK   = 1'b1;

	// drive direction codes
	typedef enum logic [1:0] {
		DIR_OFF = 2'd0,
		DIR_FWD = 2'd1,
		DIR_REV = 2'd2
	} dir_t;

	// command scale
	localparam logic [7:0] CMD_MID   = 8'd90;
	localparam logic [7:0] CMD_MAX   = 8'd180;
	localparam logic [7:0] FWD_ABOVE = 8'd105;
	localparam logic [7:0] REV_BELOW = 8'd75;
	localparam int FRAC_BITS = 8;

	// duty = mag*255/90 = floor(mag*17/6), done as mag*17*10923 >> 16 (exact for mag <= 90)
	localparam logic [17:0] DUTY_RECIP = 18'd185691;
	localparam int DUTY_SHIFT = 16;

	// configuration register bank
	typedef struct packed {
		logic [GAIN_W-1:0] gain_prop;
		logic [GAIN_W-1:0] gain_integ;
		logic [GAIN_W-1:0] gain_deriv;
		logic              rate_mode_on;
		logic              motor_enabled;
		logic              single_pin_mode;
	} cfg_t;

	// input beat
	typedef struct packed {
		logic               kind;
		logic [7:0]         target_value;
		logic signed [15:0] measured_speed;
	} in_beat_t;

	// result beat
	typedef struct packed {
		logic [7:0] speed_command;
		logic [7:0] pwm_duty;
		dir_t       direction;
	} out_beat_t;

endpackage

// ===== rtl/core/pmrd_cfg.sv =====
// configuration register bank for the motor rate PID drive
module pmrd_cfg
	import pmrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop       <= GAIN_PROP_RST;
			cfg_q.gain_integ      <= GAIN_INTEG_RST;
			cfg_q.gain_deriv      <= GAIN_DERIV_RST;
			cfg_q.rate_mode_on    <= RATE_MODE_RST;
			cfg_q.motor_enabled   <= MOTOR_EN_RST;
			cfg_q.single_pin_mode <= SINGLE_PIN_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GAIN_PROP:  cfg_q.gain_prop       <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_INTEG: cfg_q.gain_integ      <= cfg_data[GAIN_W-1:0];
				CFG_GAIN_DERIV: cfg_q.gain_deriv      <= cfg_data[GAIN_W-1:0];
				CFG_RATE_MODE:  cfg_q.rate_mode_on    <= cfg_data[0];
				CFG_MOTOR_EN:   cfg_q.motor_enabled   <= cfg_data[0];
				CFG_SINGLE_PIN: cfg_q.single_pin_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/pmrd_drive.sv =====
// maps a clamped command to bridge duty and direction
module pmrd_drive
	import pmrd_pkg::*;
(
	input  logic [7:0] cmd,
	input  logic       single_pin_mode,
	output out_beat_t  beat
);

	logic [6:0]  mag;
	logic [24:0] duty_prod;

	// distance from the stop point
	always_comb begin
		if (cmd >= CMD_MID) begin
			mag = 7'(cmd - CMD_MID);
		end else begin
			mag = 7'(CMD_MID - cmd);
		end
	end

	// scale 0..90 to 0..255 by reciprocal multiply
	assign duty_prod = 25'(mag) * 25'(DUTY_RECIP);

	// duty and direction pins
	always_comb begin
		beat.speed_command = cmd;
		if (single_pin_mode) begin
			beat.pwm_duty  = cmd;
			beat.direction = DIR_OFF;
		end else begin
			beat.pwm_duty = duty_prod[DUTY_SHIFT+7:DUTY_SHIFT];
			if (cmd > FWD_ABOVE) begin
				beat.direction = DIR_FWD;
			end else if (cmd < REV_BELOW) begin
				beat.direction = DIR_REV;
			end else begin
				beat.direction = DIR_OFF;
			end
		end
	end

endmodule

// ===== rtl/core/pid_motor_rate_drive.sv =====
// top level: motor speed PID loop with H-bridge PWM duty and direction
// a taken beat passes the stage 1, 2 and 3 registers and the output register; out_ready can stall each
// throughput: one input beat per cycle unless stalled; the loop state is updated at the accepting edge
// stages: state update, three gain multiplies, sum and clamp, duty mapping into the output register
// reset: arst_n clears gains to defaults, target, integral, last error and all stage valids
module pid_motor_rate_drive
	import pmrd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_beat_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic signed [47:0] T_MID = 48'sd23040;  // 90 in Q.8
	localparam logic signed [47:0] T_MAX = 48'sd46080;  // 180 in Q.8

	cfg_t cfg;

	// loop state
	logic signed [7:0]  target_q;
	logic signed [31:0] integ_q;
	logic signed [16:0] last_err_q;

	// stage registers
	logic               valid_s1, stop_s1;
	logic signed [16:0] err_s1;
	logic signed [31:0] integ_s1;
	logic signed [17:0] derr_s1;
	logic               valid_s2, stop_s2;
	logic signed [29:0] p_s2;
	logic signed [44:0] i_s2;
	logic signed [30:0] d_s2;
	logic               valid_s3;
	logic [7:0]         cmd_s3;
	logic               out_valid_q;
	out_beat_t          out_data_q;

	// combinational
	logic               in_fire, tick_run, is_stop, res_c;
	logic [7:0]         tv_c, tdiff_c;
	logic signed [16:0] err_c;
	logic signed [32:0] isum_c;
	logic signed [31:0] isat_c;
	logic signed [17:0] derr_c;
	logic signed [46:0] sum_c;
	logic signed [47:0] t_c;
	logic [7:0]         cmd_c;
	logic               rdy_out, rdy_s3, rdy_s2, rdy_s1;
	out_beat_t          drive_c;

	pmrd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage ready chain, bubbles are squeezed out
	assign rdy_out  = !out_valid_q || out_ready;
	assign rdy_s3   = !valid_s3 || rdy_out;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign in_fire  = in_valid && in_ready;

	// input decode, error and saturated integral
	assign tick_run = cfg.motor_enabled && cfg.rate_mode_on;
	assign tv_c     = (in_data.target_value > CMD_MAX) ? CMD_MAX : in_data.target_value;
	assign tdiff_c  = tv_c - CMD_MID;
	assign is_stop  = (in_data.kind == KIND_TARGET) && (tv_c == CMD_MID);
	assign res_c    = is_stop || ((in_data.kind == KIND_TICK) && tick_run);
	assign err_c    = 17'(in_data.measured_speed) - 17'(target_q);
	assign isum_c   = 33'(integ_q) + 33'(err_c);
	assign derr_c   = 18'(err_c) - 18'(last_err_q);

	always_comb begin
		if (isum_c[32] != isum_c[31]) begin
			isat_c = isum_c[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			isat_c = isum_c[31:0];
		end
	end

	// loop state update on each taken target beat, and on each taken tick beat while running
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q   <= '0;
			integ_q    <= '0;
			last_err_q <= '0;
		end else if (in_fire) begin
			if (in_data.kind == KIND_TARGET) begin
				target_q <= $signed(tdiff_c);
				if (is_stop) begin
					integ_q    <= '0;
					last_err_q <= '0;
				end
			end else if (tick_run) begin
				integ_q    <= isat_c;
				last_err_q <= err_c;
			end
		end
	end

	// stage 1: error terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= in_fire && res_c;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_fire) begin
			stop_s1  <= in_data.kind == KIND_TARGET;
			err_s1   <= err_c;
			integ_s1 <= isat_c;
			derr_s1  <= derr_c;
		end
	end

	// stage 2: gain products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			stop_s2 <= stop_s1;
			p_s2    <= $signed({1'b0, cfg.gain_prop}) * err_s1;
			i_s2    <= $signed({1'b0, cfg.gain_integ}) * integ_s1;
			d_s2    <= $signed({1'b0, cfg.gain_deriv}) * derr_s1;
		end
	end

	// sum and clamp to 0..180, floor of the Q.8 value; a target stop beat gives the midpoint
	assign sum_c = 47'(p_s2) + 47'(i_s2) + 47'(d_s2);
	assign t_c   = T_MID - 48'(sum_c);

	always_comb begin
		if (stop_s2) begin
			cmd_c = CMD_MID;
		end else if (t_c <= 48'sd0) begin
			cmd_c = '0;
		end else if (t_c >= T_MAX) begin
			cmd_c = CMD_MAX;
		end else begin
			cmd_c = t_c[FRAC_BITS+7:FRAC_BITS];
		end
	end

	// stage 3: command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			cmd_s3 <= cmd_c;
		end
	end

	pmrd_drive u_drive (
		.cmd             (cmd_s3),
		.single_pin_mode (cfg.single_pin_mode),
		.beat            (drive_c)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && valid_s3) begin
			out_data_q <= drive_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/core/pmrd_checker.sv =====
// port-level checks for the motor rate PID drive, bound to the top level
module pmrd_checker
	import pmrd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input in_beat_t              in_data,
	input logic                  out_valid,
	input logic                  out_ready,
	input out_beat_t             out_data,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// command never leaves the clamp range
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.speed_command <= CMD_MAX)
		else $error("command out of range");

	// direction agrees with the command thresholds
	a_dir_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.direction != DIR_FWD || out_data.speed_command > FWD_ABOVE)
			&& (out_data.direction != DIR_REV || out_data.speed_command < REV_BELOW))
		else $error("direction does not match command");

	// stopped command gives no drive
	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.speed_command == CMD_MID |->
			out_data.direction == DIR_OFF
			&& (out_data.pwm_duty == 8'd0 || out_data.pwm_duty == CMD_MID))
		else $error("stop command still drives the bridge");

endmodule

bind pid_motor_rate_drive pmrd_checker u_pmrd_checker (.*);
